FILE: src/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [2:0] CLASS_DATA  = 3'd0;
	localparam logic [2:0] CLASS_CLOSE = 3'd1;
	localparam logic [2:0] CLASS_PING  = 3'd2;
	localparam logic [2:0] CLASS_PONG  = 3'd3;
	localparam logic [2:0] CLASS_OTHER = 3'd4;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic [3:0] frame_opcode;
		logic [2:0] frame_class;
		logic       frame_end;
	} result_t;

	function automatic logic [2:0] class_of(input logic [3:0] op);
		logic [2:0] cls;
		case (op)
			OP_CONT, OP_TEXT: cls = CLASS_DATA;
			OP_CLOSE:         cls = CLASS_CLOSE;
			OP_PING:          cls = CLASS_PING;
			OP_PONG:          cls = CLASS_PONG;
			default:          cls = CLASS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

FILE: src/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [7:0]         byte_in,
	output wsd_pkg::result_t   res
);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_MASK = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        mask_q, mask_n;
	logic [63:0] rem_q, rem_n;
	logic [2:0]  ext_q, ext_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  idx_q, idx_n;
	logic [7:0]  key_byte;

	always_comb begin
		phase_n  = phase_q;
		opcode_n = opcode_q;
		mask_n   = mask_q;
		rem_n    = rem_q;
		ext_n    = ext_q;
		key_n    = key_q;
		idx_n    = idx_q;
		key_byte = 8'd0;
		res               = '0;
		res.frame_opcode  = opcode_q;
		res.frame_class   = wsd_pkg::class_of(opcode_q);
		case (phase_q)
			PH_HDR1: begin
				mask_n = byte_in[7];
				key_n  = 32'd0;
				rem_n  = 64'd0;
				if (byte_in[6:0] == wsd_pkg::LEN_EXT16) begin
					ext_n   = 3'd1;
					phase_n = PH_EXT;
				end else if (byte_in[6:0] == wsd_pkg::LEN_EXT64) begin
					ext_n   = 3'd7;
					phase_n = PH_EXT;
				end else begin
					rem_n = {57'd0, byte_in[6:0]};
					idx_n = 2'd0;
					if (mask_n) begin
						phase_n = PH_MASK;
					end else if (rem_n == 64'd0) begin
						phase_n       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_EXT: begin
				rem_n = {rem_q[55:0], byte_in};
				if (ext_q == 3'd0) begin
					idx_n = 2'd0;
					if (mask_q) begin
						phase_n = PH_MASK;
					end else if (rem_n == 64'd0) begin
						phase_n       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					ext_n = ext_q - 3'd1;
				end
			end
			PH_MASK: begin
				key_n = {key_q[23:0], byte_in};
				if (idx_q == 2'd3) begin
					idx_n = 2'd0;
					if (rem_q == 64'd0) begin
						phase_n       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					idx_n = idx_q + 2'd1;
				end
			end
			PH_DATA: begin
				if (mask_q) begin
					case (idx_q)
						2'd0:    key_byte = key_q[31:24];
						2'd1:    key_byte = key_q[23:16];
						2'd2:    key_byte = key_q[15:8];
						default: key_byte = key_q[7:0];
					endcase
				end
				idx_n = idx_q + 2'd1;
				rem_n = rem_q - 64'd1;
				res.valid         = 1'b1;
				res.payload_valid = 1'b1;
				res.payload_byte  = byte_in ^ key_byte;
				res.frame_end     = (rem_n == 64'd0);
				if (rem_n == 64'd0) begin
					phase_n = PH_HDR0;
				end
			end
			default: begin
				opcode_n = byte_in[3:0];
				phase_n  = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			rem_q    <= 64'd0;
			ext_q    <= 3'd0;
			key_q    <= 32'd0;
			idx_q    <= 2'd0;
		end else if (advance) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			mask_q   <= mask_n;
			rem_q    <= rem_n;
			ext_q    <= ext_n;
			key_q    <= key_n;
			idx_q    <= idx_n;
		end
	end

endmodule

FILE: src/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Words
// input     in         in_valid / in_stall   link_byte
// output    out        out_valid / out_stall payload_byte, payload_valid, frame_opcode,
//                                            frame_class, frame_end
//
// One byte per cycle sustained while out_stall is low; a byte passes from the input
// register to the result register, where its result is offered. Header bytes give no
// result unless they end an empty frame; the parser state advances as the byte leaves
// the input register. arst_n clears valid_s1, the result register and all parser state.
// out_stall holds a valid result and, once the input register is full, raises in_stall.

module websocket_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] link_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic [3:0] frame_opcode,
	output logic [2:0] frame_class,
	output logic       frame_end
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	wsd_pkg::result_t  res;
	wsd_pkg::result_t  out_q;

	assign advance  = valid_s1 && (!out_q.valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= link_byte;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res;
		end else if (out_q.valid && !out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid     = out_q.valid;
	assign payload_byte  = out_q.payload_byte;
	assign payload_valid = out_q.payload_valid;
	assign frame_opcode  = out_q.frame_opcode;
	assign frame_class   = out_q.frame_class;
	assign frame_end     = out_q.frame_end;

	a_empty_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> frame_end && payload_byte == 8'd0)
		else $error("empty result must end its frame with a zero byte");

	a_class_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_class == wsd_pkg::class_of(frame_opcode))
		else $error("frame class disagrees with opcode");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> out_valid)
		else $error("parser result lost");

endmodule
